FILE: design/acs_pkg.sv
// ============================================================================
// acs_pkg
// Shared types, constants and helpers for the autokey cipher stream block.
// ============================================================================
package acs_pkg;

    localparam int KEY_MAX_DEF   = 12;
    localparam int LETTER_W      = 5;
    localparam int KEY_LETTERS_W = 60;
    localparam int MID_DEPTH     = 2;
    localparam int OUT_DEPTH     = 2;

    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [5:0] ALPHABET_LEN  = 6'd26;

    // configuration register indexes
    localparam logic [1:0] CFG_CIPHER_MODE = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_KEY_LETTERS = 2'd2;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef struct packed {
        logic [7:0] char_in;
        logic       message_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_letter;
    } out_item_t;

    // classified character, front to back
    typedef struct packed {
        logic [7:0]          char_in;
        logic [LETTER_W-1:0] letter;
        logic                not_letter;
        logic                message_start;
    } mid_t;

    typedef struct packed {
        logic                     cipher_mode;
        logic [3:0]               key_length;
        logic [KEY_LETTERS_W-1:0] key_letters;
    } cfg_t;

    // key letters 26..31 wrap to 0..5
    function automatic logic [LETTER_W-1:0] fold_key(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v >= LETTER_W'(ALPHABET_LEN)) ? v - LETTER_W'(ALPHABET_LEN) : v;
        return r;
    endfunction

endpackage

FILE: design/acs_fifo.sv
// ============================================================================
// acs_fifo
// Small register queue; DEPTH is a power of two, at least 2.
// ============================================================================
module acs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: design/acs_front.sv
// ============================================================================
// acs_front
// Classifies an incoming character: folds case, extracts the letter index.
// ============================================================================
module acs_front (
    input  acs_pkg::in_item_t item,
    output acs_pkg::mid_t     classified
);
    import acs_pkg::*;

    logic is_upper;
    logic is_lower;

    assign is_upper = (item.char_in >= ASCII_UPPER_A) && (item.char_in <= ASCII_UPPER_Z);
    assign is_lower = (item.char_in >= ASCII_LOWER_A) && (item.char_in <= ASCII_LOWER_Z);

    always_comb
    begin
        classified.char_in       = item.char_in;
        classified.message_start = item.message_start;
        classified.not_letter    = !(is_upper || is_lower);
        priority if (is_upper)
        begin
            classified.letter = LETTER_W'(item.char_in - ASCII_UPPER_A);
        end
        else if (is_lower)
        begin
            classified.letter = LETTER_W'(item.char_in - ASCII_LOWER_A);
        end
        else
        begin
            classified.letter = '0;
        end
    end

endmodule

FILE: design/acs_back.sv
// ============================================================================
// acs_back
// Holds the running key queue and enciphers/deciphers one letter per beat.
// ============================================================================
module acs_back #(
    parameter int KEY_MAX = acs_pkg::KEY_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  acs_pkg::cfg_t      cfg,
    input  acs_pkg::mid_t      item,
    input  logic               item_valid,
    output logic               item_take,
    input  logic               res_full,
    output logic               res_push,
    output acs_pkg::out_item_t res
);
    import acs_pkg::*;

    logic [LETTER_W-1:0] key_q_reg  [KEY_MAX];
    logic [LETTER_W-1:0] key_q_next [KEY_MAX];
    logic [LETTER_W-1:0] base       [KEY_MAX];
    logic [LETTER_W-1:0] shifted    [KEY_MAX];
    logic                loaded_reg;
    logic                reload;
    logic [LETTER_W-1:0] key;
    logic [LETTER_W:0]   sum;
    logic [LETTER_W-1:0] enc;
    logic [LETTER_W-1:0] dec;
    logic [LETTER_W-1:0] result;
    logic [LETTER_W-1:0] plain;
    logic [3:0]          len;

    assign item_take = item_valid && !res_full;
    assign res_push  = item_take;
    assign reload    = item.message_start || !loaded_reg;

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            base[i] = reload ? fold_key(cfg.key_letters[LETTER_W*i +: LETTER_W])
                             : key_q_reg[i];
        end
        key = base[0];

        sum = {1'b0, item.letter} + {1'b0, key};
        enc = (sum >= ALPHABET_LEN) ? LETTER_W'(sum - ALPHABET_LEN) : LETTER_W'(sum);
        dec = (item.letter >= key) ? item.letter - key
                                   : LETTER_W'({1'b0, item.letter} + ALPHABET_LEN
                                               - {1'b0, key});
        if (cfg.cipher_mode == MODE_DECRYPT)
        begin
            result = dec;
            plain  = dec;
        end
        else
        begin
            result = enc;
            plain  = item.letter;
        end

        if (cfg.key_length == '0)
        begin
            len = 4'd1;
        end
        else if (cfg.key_length > 4'(KEY_MAX))
        begin
            len = 4'(KEY_MAX);
        end
        else
        begin
            len = cfg.key_length;
        end

        // shift towards the head, plaintext letter lands at the key length
        for (int i = 0; i < KEY_MAX - 1; i++)
        begin
            shifted[i] = (4'(i + 1) == len) ? plain : base[i + 1];
        end
        shifted[KEY_MAX-1] = (4'(KEY_MAX) == len) ? plain : '0;

        for (int i = 0; i < KEY_MAX; i++)
        begin
            key_q_next[i] = item.not_letter ? base[i] : shifted[i];
        end

        res.not_letter = item.not_letter;
        res.char_out   = item.not_letter ? item.char_in
                                         : 8'(result) + ASCII_UPPER_A;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            for (int i = 0; i < KEY_MAX; i++)
            begin
                key_q_reg[i] <= '0;
            end
        end
        else if (item_take)
        begin
            loaded_reg <= 1'b1;
            for (int i = 0; i < KEY_MAX; i++)
            begin
                key_q_reg[i] <= key_q_next[i];
            end
        end
    end

endmodule

FILE: design/autokey_cipher_stream_top.sv
// ============================================================================
// autokey_cipher_stream_top
// Autokey Vigenere cipher, one ASCII character per beat.
// ============================================================================
// Input channel: queue style. A character is taken when push is high and
// full is low; message_start reloads the key stream from the key registers.
// Result channel: queue style. The oldest result is on out_item while empty
// is low and leaves when pop is high.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Index 0 cipher mode, 1 key length, 2 key letters. Key letter
// writes take effect at the next key reload, mode and key length writes on
// the next character; write only while the block is drained. Path: a pushed
// character is registered in the classify queue, ciphered at its head and
// registered in the result queue; one character per cycle while that has room.
// Stall: when the receiver stops popping, the two-entry result queue fills,
// then the two-entry classify queue, then full rises.
// Reset: both queues empty, registers at mode encrypt, key length 1, key
// letters zero; the key queue is loaded on the first character.
// ============================================================================
module autokey_cipher_stream_top #(
    parameter int KEY_MAX = acs_pkg::KEY_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  acs_pkg::in_item_t                 in_item,
    output logic                              empty,
    input  logic                              pop,
    output acs_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [acs_pkg::KEY_LETTERS_W-1:0] cfg_data
);
    import acs_pkg::*;

    logic                     mode_reg;
    logic [3:0]               length_reg;
    logic [KEY_LETTERS_W-1:0] letters_reg;
    cfg_t                     cfg;
    mid_t                     classified;
    mid_t                     mid_head;
    logic                     mid_empty;
    logic                     mid_take;
    logic                     out_full;
    logic                     back_push;
    out_item_t                back_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ENCRYPT;
            length_reg  <= 4'd1;
            letters_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CIPHER_MODE: mode_reg    <= cfg_data[0];
                CFG_KEY_LENGTH:  length_reg  <= cfg_data[3:0];
                CFG_KEY_LETTERS: letters_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.cipher_mode = mode_reg;
    assign cfg.key_length  = length_reg;
    assign cfg.key_letters = letters_reg;

    acs_front u_front (
        .item       (in_item),
        .classified (classified)
    );

    acs_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (classified),
        .full  (full),
        .pop   (mid_take),
        .rdata (mid_head),
        .empty (mid_empty)
    );

    acs_back #(
        .KEY_MAX (KEY_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (mid_head),
        .item_valid (!mid_empty),
        .item_take  (mid_take),
        .res_full   (out_full),
        .res_push   (back_push),
        .res        (back_res)
    );

    acs_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_item),
        .empty (empty)
    );

    // letter results, enciphered or deciphered, are always uppercase letters
    a_letter_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.not_letter) |->
            (out_item.char_out >= ASCII_UPPER_A && out_item.char_out <= ASCII_UPPER_Z))
        else $error("letter result outside A-Z");

    // nothing in flight and nothing pushed: no result may appear
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && mid_empty && !(push && !full)) |=> empty)
        else $error("result appeared with no character in flight");

    // back end only hands over a result when the result queue has room
    a_back_room: assert property (@(posedge clk) disable iff (!rst_n)
        back_push |-> (!out_full && !mid_empty))
        else $error("back end pushed into full queue or without input");

endmodule

FILE: tb/autokey_cipher_stream_top_tb.sv
// ============================================================================
// autokey_cipher_stream_top_tb
// Self-checking bench for the autokey cipher stream block.
// ============================================================================
// Characters are pushed through the queue-style input. An in-bench cipher
// model keeps its own key stream and register copies, and computes the
// expected character for every accepted beat. A separate receiver pops
// results with random stalls and checks each one against the oldest
// expectation. Tests cover the reset defaults, register edge values, long
// random messages under varied key setups, and a long receiver hold-off
// that backs the block up until full rises.
// ============================================================================
module autokey_cipher_stream_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    in_item_t                 in_item = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    out_item_t                out_item;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = '0;
    logic [KEY_LETTERS_W-1:0] cfg_data = '0;

    // cipher model state
    logic [LETTER_W-1:0]      key_stream [KEY_MAX_DEF];
    logic                     stream_primed;
    logic                     mdl_mode;
    logic [3:0]               mdl_klen;
    logic [KEY_LETTERS_W-1:0] mdl_kletters;

    out_item_t expected_chars[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        rx_stall = 0;
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;
    logic      rx_hold = 1'b0;
    event      hold_trigger;

    autokey_cipher_stream_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** autokey_cipher_stream_top: FAILED **");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_gap(input bit en);
        int r;
        if (!en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'($urandom_range(ASCII_UPPER_A, ASCII_UPPER_Z));
        else if (r < 85)
            return 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [KEY_LETTERS_W-1:0] rand_word();
        return KEY_LETTERS_W'({$urandom, $urandom});
    endfunction

    task automatic cipher_predict(input in_item_t it, output out_item_t r);
        logic [7:0]          c;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] v;
        int                  res;
        int                  plain;
        int                  n;
        c = it.char_in;
        if (it.message_start || !stream_primed)
        begin
            for (int i = 0; i < KEY_MAX_DEF; i++)
            begin
                v = mdl_kletters[LETTER_W*i +: LETTER_W];
                key_stream[i] = (v >= 26) ? LETTER_W'(v - 26) : v;
            end
            stream_primed = 1'b1;
        end
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z)
            letter = LETTER_W'(c - ASCII_UPPER_A);
        else if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
            letter = LETTER_W'(c - ASCII_LOWER_A);
        else
        begin
            // passes through, key stream untouched
            r.char_out   = c;
            r.not_letter = 1'b1;
            return;
        end
        if (mdl_mode == MODE_DECRYPT)
        begin
            res   = (int'(letter) + 26 - int'(key_stream[0])) % 26;
            plain = res;
        end
        else
        begin
            res   = (int'(letter) + int'(key_stream[0])) % 26;
            plain = letter;
        end
        n = mdl_klen;
        if (n < 1)
            n = 1;
        if (n > KEY_MAX_DEF)
            n = KEY_MAX_DEF;
        for (int i = 0; i < KEY_MAX_DEF - 1; i++)
            key_stream[i] = key_stream[i+1];
        key_stream[KEY_MAX_DEF-1] = '0;
        key_stream[n-1] = LETTER_W'(plain);
        r.char_out   = 8'(res + ASCII_UPPER_A);
        r.not_letter = 1'b0;
    endtask

    // result checker and pop driver
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: char_out=%h not_letter=%b",
                             out_item.char_out, out_item.not_letter);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_item.char_out !== want.char_out ||
                    out_item.not_letter !== want.not_letter)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: char_out exp %h got %h, not_letter exp %b got %b",
                                 want.char_out, out_item.char_out,
                                 want.not_letter, out_item.not_letter);
                end
            end
        end
        if (rx_hold)
            pop <= 1'b0;
        else
        begin
            if (rx_stall == 0)
                rx_stall = idle_gap(rx_idle_en);
            if (rx_stall > 0)
            begin
                pop <= 1'b0;
                rx_stall--;
            end
            else
                pop <= 1'b1;
        end
    end

    // long receiver hold-off, counted here
    always
    begin
        @(hold_trigger);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic send_char(input logic [7:0] c, input logic st);
        in_item_t  it;
        out_item_t r;
        int        g;
        it.char_in       = c;
        it.message_start = st;
        push    <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (full);
        cipher_predict(it, r);
        expected_chars.push_back(r);
        g = idle_gap(tx_idle_en);
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // valid stays high across back-to-back writes; last drops it
    task automatic cfg_beat(input logic [1:0] idx, input logic [KEY_LETTERS_W-1:0] d,
                            input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        case (idx)
            CFG_CIPHER_MODE: mdl_mode     = d[0];
            CFG_KEY_LENGTH:  mdl_klen     = d[3:0];
            CFG_KEY_LETTERS: mdl_kletters = d;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        logic [7:0] chars [10];
        chars = '{8'h41, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h61, 8'h5A};
        // no start flag: the first beat still primes the key stream
        foreach (chars[i])
            send_char(chars[i], 1'b0);
    endtask

    task automatic test_register_edges();
        logic [LETTER_W-1:0]      pat [KEY_MAX_DEF];
        logic [KEY_LETTERS_W-1:0] kl;
        logic [7:0]               msg [6];
        pat = '{5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd25, 5'd0,
                5'd1, 5'd13, 5'd24, 5'd12};
        foreach (pat[i])
            kl[LETTER_W*i +: LETTER_W] = pat[i];
        drain_results();
        cfg_beat(CFG_CIPHER_MODE, {59'h7FF_FFFF_FFFF_FFFF, MODE_ENCRYPT}, 1'b0);
        cfg_beat(CFG_KEY_LENGTH, {KEY_LETTERS_W{1'b1}}, 1'b0);
        cfg_beat(CFG_KEY_LETTERS, kl, 1'b0);
        cfg_beat(2'd3, rand_word(), 1'b1);
        msg = '{8'h48, 8'h65, 8'h6C, 8'h6C, 8'h4F, 8'h21};
        foreach (msg[i])
            send_char(msg[i], i == 0);
        // reload on a non-letter, then a letter off the fresh key
        send_char(8'h20, 1'b1);
        send_char(8'h77, 1'b0);
        drain_results();
        cfg_beat(CFG_CIPHER_MODE, KEY_LETTERS_W'(MODE_DECRYPT), 1'b0);
        cfg_beat(CFG_KEY_LENGTH, '0, 1'b0);
        cfg_beat(CFG_KEY_LETTERS, rand_word(), 1'b1);
        send_char(8'h51, 1'b1);
        send_char(8'h78, 1'b0);
        send_char(8'h39, 1'b0);
        send_char(8'h6B, 1'b0);
    endtask

    task automatic test_random_messages();
        logic [KEY_LETTERS_W-1:0] len_d;
        logic [KEY_LETTERS_W-1:0] key_d;
        logic [KEY_LETTERS_W-1:0] mode_d;
        int                       sent;
        int                       mlen;
        for (int ph = 0; ph < 10; ph++)
        begin
            drain_results();
            mode_d    = rand_word();
            mode_d[0] = ph[0];
            len_d     = rand_word();
            key_d     = rand_word();
            case (ph)
                0: begin len_d[3:0] = 4'd1;  key_d = '1; end
                1: begin len_d[3:0] = 4'd12; key_d = '0; end
                2: len_d[3:0] = 4'd0;
                3: len_d[3:0] = 4'd15;
                default: ;
            endcase
            cfg_beat(CFG_CIPHER_MODE, mode_d, 1'b0);
            cfg_beat(CFG_KEY_LENGTH, len_d, 1'b0);
            cfg_beat(CFG_KEY_LETTERS, key_d, 1'b1);
            tx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 100)
            begin
                mlen = $urandom_range(1, 30);
                for (int i = 0; i < mlen; i++)
                begin
                    if (i == 0)
                        send_char(rand_char(), $urandom_range(0, 9) != 0);
                    else
                        send_char(rand_char(), $urandom_range(0, 49) == 0);
                end
                sent += mlen;
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        drain_results();
        tx_idle_en = 1'b0;
        -> hold_trigger;
        send_char(rand_char(), 1'b1);
        for (int i = 1; i < 40; i++)
            send_char(rand_char(), 1'b0);
        tx_idle_en = 1'b1;
        // sender stays quiet until every result is back
        drain_results();
    endtask

    initial
    begin
        mdl_mode      = MODE_ENCRYPT;
        mdl_klen      = 4'd1;
        mdl_kletters  = '0;
        stream_primed = 1'b0;
        foreach (key_stream[i])
            key_stream[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_edges();
        test_backpressure();
        test_random_messages();
        test_backpressure();

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("** autokey_cipher_stream_top: PASSED **");
        else
            $display("** autokey_cipher_stream_top: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/acs_pkg.sv
design/acs_fifo.sv
design/acs_front.sv
design/acs_back.sv
design/autokey_cipher_stream_top.sv
tb/autokey_cipher_stream_top_tb.sv
